// ===== hw/rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token codes and keyword lookup for the source text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int LINE_BITS_DEF     = 20;
  localparam int OFFSET_W          = 24;
  localparam int LENGTH_W          = 24;
  localparam int LINE_W            = 20;
  localparam int QUEUE_DEPTH       = 4;
  localparam int RUN_MAX           = 3;

  // token codes
  localparam logic [5:0] TK_LPAREN    = 6'd0;
  localparam logic [5:0] TK_RPAREN    = 6'd1;
  localparam logic [5:0] TK_LBRACE    = 6'd2;
  localparam logic [5:0] TK_RBRACE    = 6'd3;
  localparam logic [5:0] TK_COMMA     = 6'd4;
  localparam logic [5:0] TK_DOT       = 6'd5;
  localparam logic [5:0] TK_MINUS     = 6'd6;
  localparam logic [5:0] TK_PLUS      = 6'd7;
  localparam logic [5:0] TK_SEMI      = 6'd8;
  localparam logic [5:0] TK_SLASH     = 6'd9;
  localparam logic [5:0] TK_STAR      = 6'd10;
  localparam logic [5:0] TK_BANG      = 6'd11;
  localparam logic [5:0] TK_BANG_EQ   = 6'd12;
  localparam logic [5:0] TK_ASSIGN    = 6'd13;
  localparam logic [5:0] TK_EQ_EQ     = 6'd14;
  localparam logic [5:0] TK_GREATER   = 6'd15;
  localparam logic [5:0] TK_GREATER_EQ = 6'd16;
  localparam logic [5:0] TK_LESS      = 6'd17;
  localparam logic [5:0] TK_LESS_EQ   = 6'd18;
  localparam logic [5:0] TK_INHERIT   = 6'd19;
  localparam logic [5:0] TK_IDENT     = 6'd20;
  localparam logic [5:0] TK_STRING    = 6'd21;
  localparam logic [5:0] TK_NUMBER    = 6'd22;
  localparam logic [5:0] TK_ERROR     = 6'd39;
  localparam logic [5:0] TK_EOF       = 6'd40;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_OPEN_STR   = 2'd2;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7b;
  localparam logic [7:0] CH_RBRC  = 8'h7d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef struct packed {
    logic [5:0]          kind;
    logic [1:0]          err;
    logic [OFFSET_W-1:0] start;
    logic [LENGTH_W-1:0] len;
    logic [LINE_W-1:0]   line;
  } tok_t;

  typedef struct packed {
    tok_t [RUN_MAX-1:0] tok;
    logic [1:0]         cnt;
  } run_t;

  typedef struct packed {
    logic [55:0] text;
    logic [2:0]  len;
    logic [5:0]  kind;
  } kw_t;

  localparam kw_t KW_TABLE [16] = '{
    '{56'h0000000064_6e61,     3'd3, 6'd23},  // and
    '{56'h00616b61_61686b,     3'd6, 6'd24},  // khaaka
    '{56'h0000616e_726177,     3'd5, 6'd25},  // warna
    '{56'h00006573_6c6166,     3'd5, 6'd26},  // false
    '{56'h00006f72_6f6873,     3'd5, 6'd27},  // shoro
    '{56'h6c756161_666174,     3'd7, 6'd28},  // tafaaul
    '{56'h00000000_726761,     3'd3, 6'd29},  // agr
    '{56'h00000000_6c696e,     3'd3, 6'd30},  // nil
    '{56'h00000000_00726f,     3'd2, 6'd31},  // or
    '{56'h00706161_686863,     3'd6, 6'd32},  // chhaap
    '{56'h616e6174_75616c,     3'd7, 6'd33},  // lautana
    '{56'h00007265_707573,     3'd5, 6'd34},  // super
    '{56'h00000073_696874,     3'd4, 6'd35},  // this
    '{56'h00000065_757274,     3'd4, 6'd36},  // true
    '{56'h00006e61_616c65,     3'd5, 6'd37},  // elaan
    '{56'h0000006b_74626a,     3'd4, 6'd38}   // jbtk
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == 8'h5f);
  endfunction

  // Only the first len prefix bytes are compared; higher bytes are masked.
  function automatic logic [5:0] kw_kind(input logic [55:0] prefix,
                                         input logic [2:0] len, input logic fits);
    logic [5:0] k;
    k = TK_IDENT;
    for (int i = 0; i < 16; i++) begin
      if (fits && (KW_TABLE[i].len == len)) begin
        if (((prefix ^ KW_TABLE[i].text) &
             ~({56{1'b1}} << (8 * int'(len)))) == 56'd0) begin
          k = KW_TABLE[i].kind;
        end
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stt_channels.sv =====
// ----------------------------------------------------------------------------
// stt_in_if / stt_out_if
// Valid/ready channels for source bytes and emitted tokens.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;
  modport source (output valid, char_code, end_of_text, input ready);
  modport sink (input valid, char_code, end_of_text, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [1:0]  error_kind;
  logic [23:0] start_offset;
  logic [23:0] token_length;
  logic [19:0] line_number;
  logic        last_of_run;
  modport source (output valid, token_kind, error_kind, start_offset, token_length,
                  line_number, last_of_run, input ready);
  modport sink (input valid, token_kind, error_kind, start_offset, token_length,
                line_number, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front
// Scan state machine: a byte per cycle unless full; emits up to three tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front #(
  parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
  parameter int LINE_BITS     = stt_pkg::LINE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  stt_in_if.sink           in_ch,
  input  wire logic        full,
  output stt_pkg::run_t    run,
  output logic             push
);
  import stt_pkg::*;

  localparam int P     = POSITION_BITS;
  localparam int WIDE  = (P + 1 > LENGTH_W) ? P + 1 : LENGTH_W;
  localparam int LWIDE = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_SLASH, M_IDENT, M_NUMBER, M_NUMDOT, M_FRACTION,
    M_STRING, M_BANG, M_EQUAL, M_LESS, M_GREATER, M_MINUS, M_DONE
  } mode_t;

  mode_t                mode, mode_next;
  logic [P-1:0]         pos, pos_next;
  logic [P-1:0]         tstart, tstart_next;
  logic [LINE_BITS-1:0] line, line_next;
  logic [55:0]          prefix, prefix_next;

  tok_t [RUN_MAX-1:0]   toks;
  logic [1:0]           n;
  logic                 take;
  logic [7:0]           c;
  logic                 do_idle;
  logic [P:0]           posx, posp1, posm1, startx;
  logic [P-1:0]         diff;
  logic [5:0]           ident_k;
  logic [LWIDE-1:0]     line_w;

  function automatic tok_t mk(input logic [5:0] k, input logic [1:0] er,
                              input logic [P:0] s, input logic [P:0] e);
    logic [P:0]      d;
    logic [WIDE-1:0] dw;
    logic [WIDE-1:0] sw;
    logic            sat;
    tok_t            t;
    d   = (e > s) ? e - s : '0;
    dw  = WIDE'(d);
    sw  = WIDE'(s);
    sat = 1'b0;
    for (int i = LENGTH_W; i <= P; i++) sat = sat | d[i];
    t.kind  = k;
    t.err   = er;
    t.start = sw[OFFSET_W-1:0];
    t.len   = sat ? {LENGTH_W{1'b1}} : dw[LENGTH_W-1:0];
    t.line  = '0;
    return t;
  endfunction

  assign take        = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !full;
  assign c           = in_ch.char_code;
  assign posx        = {1'b0, pos};
  assign posp1       = posx + 1'b1;
  assign posm1       = posx - 1'b1;
  assign startx      = {1'b0, tstart};
  assign diff        = pos - tstart;
  assign ident_k     = kw_kind(prefix, diff[2:0], diff < P'(8));
  assign line_w      = LWIDE'(line);

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    tstart_next = tstart;
    line_next   = line;
    prefix_next = prefix;
    toks        = '0;
    n           = 2'd0;
    do_idle     = 1'b0;

    if (mode == M_DONE) begin
      toks[n] = mk(TK_EOF, ERR_NONE, posx, posx); n = n + 2'd1;
    end else if (in_ch.end_of_text || (c == CH_NUL)) begin
      case (mode)
        M_SLASH: begin
          toks[n] = mk(TK_SLASH, ERR_NONE, startx, posx); n = n + 2'd1;
        end
        M_IDENT: begin
          toks[n] = mk(ident_k, ERR_NONE, startx, posx); n = n + 2'd1;
        end
        M_NUMBER, M_FRACTION: begin
          toks[n] = mk(TK_NUMBER, ERR_NONE, startx, posx); n = n + 2'd1;
        end
        M_NUMDOT: begin
          toks[n] = mk(TK_NUMBER, ERR_NONE, startx, posm1); n = n + 2'd1;
          toks[n] = mk(TK_DOT, ERR_NONE, posm1, posx); n = n + 2'd1;
        end
        M_STRING: begin
          toks[n] = mk(TK_ERROR, ERR_OPEN_STR, startx, startx); n = n + 2'd1;
        end
        M_BANG: begin
          toks[n] = mk(TK_BANG, ERR_NONE, startx, posx); n = n + 2'd1;
        end
        M_EQUAL: begin
          toks[n] = mk(TK_ERROR, ERR_UNEXPECTED, startx, startx); n = n + 2'd1;
        end
        M_LESS: begin
          toks[n] = mk(TK_LESS, ERR_NONE, startx, posx); n = n + 2'd1;
        end
        M_GREATER: begin
          toks[n] = mk(TK_GREATER, ERR_NONE, startx, posx); n = n + 2'd1;
        end
        M_MINUS: begin
          toks[n] = mk(TK_MINUS, ERR_NONE, startx, posx); n = n + 2'd1;
        end
        default: begin
        end
      endcase
      toks[n] = mk(TK_EOF, ERR_NONE, posx, posx); n = n + 2'd1;
      mode_next = M_DONE;
    end else begin
      case (mode)
        M_COMMENT: begin
          if (c == CH_LF) do_idle = 1'b1;
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_next = M_COMMENT;
          end else begin
            toks[n] = mk(TK_SLASH, ERR_NONE, startx, posx); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (diff < P'(7)) prefix_next[8*diff[2:0] +: 8] = prefix[8*diff[2:0] +: 8] | c;
          end else begin
            toks[n] = mk(ident_k, ERR_NONE, startx, posx); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (c == CH_DOT) begin
            mode_next = M_NUMDOT;
          end else if (!is_digit(c)) begin
            toks[n] = mk(TK_NUMBER, ERR_NONE, startx, posx); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (is_digit(c)) begin
            mode_next = M_FRACTION;
          end else begin
            toks[n] = mk(TK_NUMBER, ERR_NONE, startx, posm1); n = n + 2'd1;
            toks[n] = mk(TK_DOT, ERR_NONE, posm1, posx); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_FRACTION: begin
          if (!is_digit(c)) begin
            toks[n] = mk(TK_NUMBER, ERR_NONE, startx, posx); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_STRING: begin
          if (c == CH_QUOTE) begin
            toks[n] = mk(TK_STRING, ERR_NONE, startx, posp1); n = n + 2'd1;
            mode_next = M_IDLE;
          end else if ((c == CH_LF) && (line != {LINE_BITS{1'b1}})) begin
            line_next = line + 1'b1;
          end
        end
        M_BANG: begin
          if (c == CH_EQ) begin
            toks[n] = mk(TK_BANG_EQ, ERR_NONE, startx, posp1); n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            toks[n] = mk(TK_BANG, ERR_NONE, startx, posx); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_EQUAL: begin
          if (c == CH_EQ) begin
            toks[n] = mk(TK_EQ_EQ, ERR_NONE, startx, posp1); n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            toks[n] = mk(TK_ERROR, ERR_UNEXPECTED, startx, startx); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_LESS: begin
          if (c == CH_EQ) begin
            toks[n] = mk(TK_LESS_EQ, ERR_NONE, startx, posp1); n = n + 2'd1;
            mode_next = M_IDLE;
          end else if (c == CH_MINUS) begin
            toks[n] = mk(TK_ASSIGN, ERR_NONE, startx, posp1); n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            toks[n] = mk(TK_LESS, ERR_NONE, startx, posx); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_GREATER: begin
          if (c == CH_EQ) begin
            toks[n] = mk(TK_GREATER_EQ, ERR_NONE, startx, posp1); n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            toks[n] = mk(TK_GREATER, ERR_NONE, startx, posx); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_MINUS: begin
          if (c == CH_GT) begin
            toks[n] = mk(TK_INHERIT, ERR_NONE, startx, posp1); n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            toks[n] = mk(TK_MINUS, ERR_NONE, startx, posx); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        mode_next   = M_IDLE;
        tstart_next = pos;
        case (c)
          CH_SPACE, CH_CR, CH_TAB: begin
          end
          CH_LF: begin
            if (line != {LINE_BITS{1'b1}}) line_next = line + 1'b1;
          end
          CH_LPAR:  begin toks[n] = mk(TK_LPAREN, ERR_NONE, posx, posp1); n = n + 2'd1; end
          CH_RPAR:  begin toks[n] = mk(TK_RPAREN, ERR_NONE, posx, posp1); n = n + 2'd1; end
          CH_LBRC:  begin toks[n] = mk(TK_LBRACE, ERR_NONE, posx, posp1); n = n + 2'd1; end
          CH_RBRC:  begin toks[n] = mk(TK_RBRACE, ERR_NONE, posx, posp1); n = n + 2'd1; end
          CH_COMMA: begin toks[n] = mk(TK_COMMA, ERR_NONE, posx, posp1); n = n + 2'd1; end
          CH_DOT:   begin toks[n] = mk(TK_DOT, ERR_NONE, posx, posp1); n = n + 2'd1; end
          CH_PLUS:  begin toks[n] = mk(TK_PLUS, ERR_NONE, posx, posp1); n = n + 2'd1; end
          CH_SEMI:  begin toks[n] = mk(TK_SEMI, ERR_NONE, posx, posp1); n = n + 2'd1; end
          CH_STAR:  begin toks[n] = mk(TK_STAR, ERR_NONE, posx, posp1); n = n + 2'd1; end
          CH_SLASH: mode_next = M_SLASH;
          CH_BANG:  mode_next = M_BANG;
          CH_EQ:    mode_next = M_EQUAL;
          CH_LT:    mode_next = M_LESS;
          CH_GT:    mode_next = M_GREATER;
          CH_MINUS: mode_next = M_MINUS;
          CH_QUOTE: mode_next = M_STRING;
          default: begin
            if (is_alpha(c)) begin
              mode_next   = M_IDENT;
              prefix_next = {48'd0, c};
            end else if (is_digit(c)) begin
              mode_next = M_NUMBER;
            end else begin
              toks[n] = mk(TK_ERROR, ERR_UNEXPECTED, posx, posx); n = n + 2'd1;
            end
          end
        endcase
      end

      // hold at the top of the range
      if (pos != {P{1'b1}}) pos_next = pos + 1'b1;
    end

    for (int i = 0; i < RUN_MAX; i++) toks[i].line = line_w[LINE_W-1:0];
  end

  assign run.tok = toks;
  assign run.cnt = n;
  assign push    = take && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      tstart <= '0;
      line   <= LINE_BITS'(1);
      prefix <= '0;
    end else if (take) begin
      mode   <= mode_next;
      pos    <= pos_next;
      tstart <= tstart_next;
      line   <= line_next;
      prefix <= prefix_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue
// Short queue of token runs between the scanner and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  stt_pkg::run_t      push_run,
  input  wire logic          pop,
  output logic               full,
  output logic               head_valid,
  output stt_pkg::run_t      head
);
  import stt_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  run_t          mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_pop;

  assign full       = (count == (AW + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back
// Output stage: sends the tokens of the head run one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_back (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     head_valid,
  input  stt_pkg::run_t head,
  output logic          pop,
  stt_out_if.source     out_ch
);
  import stt_pkg::*;

  logic [1:0] sub;
  logic       last;
  tok_t       t;

  assign t    = head.tok[sub];
  assign last = (sub == (head.cnt - 2'd1));
  assign pop  = out_ch.valid && out_ch.ready && last;

  assign out_ch.valid        = head_valid;
  assign out_ch.token_kind   = t.kind;
  assign out_ch.error_kind   = t.err;
  assign out_ch.start_offset = t.start;
  assign out_ch.token_length = t.len;
  assign out_ch.line_number  = t.line;
  assign out_ch.last_of_run  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= '0;
    end else if (out_ch.valid && out_ch.ready) begin
      sub <= last ? 2'd0 : sub + 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexical scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  in_ch    | in  | char_code[7:0], end_of_text
//  out_ch   | out | token_kind, error_kind, start_offset, token_length,
//           |     | line_number, last_of_run
//
//  One byte is taken every cycle while the run queue has room; a byte that
//  closes tokens pushes one run of up to three tokens.
//  The output stage drains one token per cycle while out_ch is ready; the
//  four-run queue absorbs short bursts.
//  Reset (rst, synchronous) empties the queue and returns the scanner to
//  line 1, offset 0. A stall on out_ch backs up into in_ch only once the
//  queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer #(
  parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
  parameter int LINE_BITS     = stt_pkg::LINE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  stt_in_if.sink    in_ch,
  stt_out_if.source out_ch
);
  import stt_pkg::*;

  run_t push_run;
  run_t head;
  logic push;
  logic pop;
  logic full;
  logic head_valid;

  // front: classify each byte and build the token run
  stt_front #(
    .POSITION_BITS (POSITION_BITS),
    .LINE_BITS     (LINE_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .full  (full),
    .run   (push_run),
    .push  (push)
  );

  // hold runs so the scanner keeps moving while the sink stalls
  stt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_run   (push_run),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: serialize the head run onto the output channel
  stt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/tb_source_text_tokenizer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer
// Streams source text into the tokenizer under random idling on both sides,
// predicts every token with a scanner model kept in the testbench, and
// compares each emitted token field by field in order.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer;
  import stt_pkg::*;

  // keyword token codes (dense block after the literals)
  localparam logic [5:0] KW_AND = 6'd23, KW_KHAAKA = 6'd24, KW_WARNA = 6'd25,
    KW_FALSE = 6'd26, KW_SHORO = 6'd27, KW_TAFAAUL = 6'd28, KW_AGR = 6'd29,
    KW_NIL = 6'd30, KW_OR = 6'd31, KW_CHHAAP = 6'd32, KW_LAUTANA = 6'd33,
    KW_SUPER = 6'd34, KW_THIS = 6'd35, KW_TRUE = 6'd36, KW_ELAAN = 6'd37,
    KW_JBTK = 6'd38;

  typedef enum logic [3:0] {
    SC_IDLE, SC_COMMENT, SC_SLASH, SC_IDENT, SC_NUMBER, SC_NUMDOT, SC_FRACTION,
    SC_STRING, SC_BANG, SC_EQUAL, SC_LESS, SC_GREATER, SC_MINUS, SC_DONE
  } scan_state_t;

  typedef struct {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [23:0] start;
    logic [23:0] len;
    logic [19:0] line;
    logic        last;
  } token_t;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } src_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  source_text_tokenizer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scanner model: state mirrors the block, tokens go to expected_tokens.
  // --------------------------------------------------------------------------
  string       kw_text [16] = '{"and", "khaaka", "warna", "false", "shoro",
                                "tafaaul", "agr", "nil", "or", "chhaap",
                                "lautana", "super", "this", "true", "elaan", "jbtk"};
  logic [5:0]  kw_code [16] = '{KW_AND, KW_KHAAKA, KW_WARNA, KW_FALSE, KW_SHORO,
                                KW_TAFAAUL, KW_AGR, KW_NIL, KW_OR, KW_CHHAAP,
                                KW_LAUTANA, KW_SUPER, KW_THIS, KW_TRUE, KW_ELAAN,
                                KW_JBTK};

  scan_state_t scan_state;
  logic [63:0] cur_pos, tok_begin, cur_line;
  logic [55:0] name_bytes;
  token_t      expected_tokens[$];
  int          run_count;

  function automatic void push_token(logic [5:0] kind, logic [1:0] err,
                                     logic [63:0] from, logic [63:0] upto);
    token_t      t;
    logic [63:0] n;
    if (run_count >= 4) return;
    n = (upto > from) ? upto - from : 64'd0;
    if (n > 64'hFFFFFF) n = 64'hFFFFFF;
    t.kind  = kind;
    t.err   = err;
    t.start = from[23:0];
    t.len   = n[23:0];
    t.line  = cur_line[19:0];
    t.last  = 1'b0;
    expected_tokens.push_back(t);
    run_count++;
  endfunction

  function automatic void bump_line();
    if (cur_line < 64'hFFFFF) cur_line++;
  endfunction

  function automatic logic digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [5:0] word_kind(logic [63:0] upto);
    logic [63:0] n;
    bit          hit;
    n = (upto > tok_begin) ? upto - tok_begin : 64'd0;
    for (int i = 0; i < 16; i++) begin
      if (kw_text[i].len() == n) begin
        hit = 1;
        for (int j = 0; j < n; j++)
          if (name_bytes[8*j +: 8] != kw_text[i][j]) hit = 0;
        if (hit) return kw_code[i];
      end
    end
    return TK_IDENT;
  endfunction

  function automatic void start_token(logic [7:0] c, logic [63:0] p);
    scan_state = SC_IDLE;
    tok_begin  = p;
    case (c)
      CH_SPACE, CH_CR, CH_TAB: return;
      CH_LF:    begin bump_line(); return; end
      CH_LPAR:  begin push_token(TK_LPAREN, ERR_NONE, p, p + 1); return; end
      CH_RPAR:  begin push_token(TK_RPAREN, ERR_NONE, p, p + 1); return; end
      CH_LBRC:  begin push_token(TK_LBRACE, ERR_NONE, p, p + 1); return; end
      CH_RBRC:  begin push_token(TK_RBRACE, ERR_NONE, p, p + 1); return; end
      CH_COMMA: begin push_token(TK_COMMA, ERR_NONE, p, p + 1); return; end
      CH_DOT:   begin push_token(TK_DOT, ERR_NONE, p, p + 1); return; end
      CH_PLUS:  begin push_token(TK_PLUS, ERR_NONE, p, p + 1); return; end
      CH_SEMI:  begin push_token(TK_SEMI, ERR_NONE, p, p + 1); return; end
      CH_STAR:  begin push_token(TK_STAR, ERR_NONE, p, p + 1); return; end
      CH_SLASH: begin scan_state = SC_SLASH; return; end
      CH_BANG:  begin scan_state = SC_BANG; return; end
      CH_EQ:    begin scan_state = SC_EQUAL; return; end
      CH_LT:    begin scan_state = SC_LESS; return; end
      CH_GT:    begin scan_state = SC_GREATER; return; end
      CH_MINUS: begin scan_state = SC_MINUS; return; end
      CH_QUOTE: begin scan_state = SC_STRING; return; end
      default: ;
    endcase
    if (letter(c)) begin
      scan_state = SC_IDENT;
      name_bytes = {48'd0, c};
    end else if (digit(c)) begin
      scan_state = SC_NUMBER;
    end else begin
      push_token(TK_ERROR, ERR_UNEXPECTED, p, p);
    end
  endfunction

  // Close or extend the pending token with byte c, then rescan c if closed.
  function automatic void scan_char(logic [7:0] c, logic [63:0] p);
    logic [63:0] idx;
    case (scan_state)
      SC_COMMENT: begin
        if (c == CH_LF) start_token(c, p);
        return;
      end
      SC_SLASH: begin
        if (c == CH_SLASH) begin scan_state = SC_COMMENT; return; end
        push_token(TK_SLASH, ERR_NONE, tok_begin, p);
      end
      SC_IDENT: begin
        if (letter(c) || digit(c)) begin
          idx = (p > tok_begin) ? p - tok_begin : 64'd0;
          if (idx < 7) name_bytes[8*idx +: 8] = c;
          return;
        end
        push_token(word_kind(p), ERR_NONE, tok_begin, p);
      end
      SC_NUMBER: begin
        if (digit(c)) return;
        if (c == CH_DOT) begin scan_state = SC_NUMDOT; return; end
        push_token(TK_NUMBER, ERR_NONE, tok_begin, p);
      end
      SC_NUMDOT: begin
        if (digit(c)) begin scan_state = SC_FRACTION; return; end
        push_token(TK_NUMBER, ERR_NONE, tok_begin, p - 1);
        push_token(TK_DOT, ERR_NONE, p - 1, p);
      end
      SC_FRACTION: begin
        if (digit(c)) return;
        push_token(TK_NUMBER, ERR_NONE, tok_begin, p);
      end
      SC_STRING: begin
        if (c == CH_QUOTE) begin
          push_token(TK_STRING, ERR_NONE, tok_begin, p + 1);
          scan_state = SC_IDLE;
        end else if (c == CH_LF) begin
          bump_line();
        end
        return;
      end
      SC_BANG: begin
        if (c == CH_EQ) begin
          push_token(TK_BANG_EQ, ERR_NONE, tok_begin, p + 1);
          scan_state = SC_IDLE;
          return;
        end
        push_token(TK_BANG, ERR_NONE, tok_begin, p);
      end
      SC_EQUAL: begin
        if (c == CH_EQ) begin
          push_token(TK_EQ_EQ, ERR_NONE, tok_begin, p + 1);
          scan_state = SC_IDLE;
          return;
        end
        push_token(TK_ERROR, ERR_UNEXPECTED, tok_begin, tok_begin);
      end
      SC_LESS: begin
        if (c == CH_EQ) begin
          push_token(TK_LESS_EQ, ERR_NONE, tok_begin, p + 1);
          scan_state = SC_IDLE;
          return;
        end
        if (c == CH_MINUS) begin
          push_token(TK_ASSIGN, ERR_NONE, tok_begin, p + 1);
          scan_state = SC_IDLE;
          return;
        end
        push_token(TK_LESS, ERR_NONE, tok_begin, p);
      end
      SC_GREATER: begin
        if (c == CH_EQ) begin
          push_token(TK_GREATER_EQ, ERR_NONE, tok_begin, p + 1);
          scan_state = SC_IDLE;
          return;
        end
        push_token(TK_GREATER, ERR_NONE, tok_begin, p);
      end
      SC_MINUS: begin
        if (c == CH_GT) begin
          push_token(TK_INHERIT, ERR_NONE, tok_begin, p + 1);
          scan_state = SC_IDLE;
          return;
        end
        push_token(TK_MINUS, ERR_NONE, tok_begin, p);
      end
      default: ;
    endcase
    start_token(c, p);
  endfunction

  // Flush whatever token is open at the end mark, then EOF.
  function automatic void flush_text(logic [63:0] p);
    case (scan_state)
      SC_SLASH:   push_token(TK_SLASH, ERR_NONE, tok_begin, p);
      SC_IDENT:   push_token(word_kind(p), ERR_NONE, tok_begin, p);
      SC_NUMBER, SC_FRACTION: push_token(TK_NUMBER, ERR_NONE, tok_begin, p);
      SC_NUMDOT: begin
        push_token(TK_NUMBER, ERR_NONE, tok_begin, p - 1);
        push_token(TK_DOT, ERR_NONE, p - 1, p);
      end
      SC_STRING:  push_token(TK_ERROR, ERR_OPEN_STR, tok_begin, tok_begin);
      SC_BANG:    push_token(TK_BANG, ERR_NONE, tok_begin, p);
      SC_EQUAL:   push_token(TK_ERROR, ERR_UNEXPECTED, tok_begin, tok_begin);
      SC_LESS:    push_token(TK_LESS, ERR_NONE, tok_begin, p);
      SC_GREATER: push_token(TK_GREATER, ERR_NONE, tok_begin, p);
      SC_MINUS:   push_token(TK_MINUS, ERR_NONE, tok_begin, p);
      default: ;
    endcase
    push_token(TK_EOF, ERR_NONE, p, p);
    scan_state = SC_DONE;
  endfunction

  function automatic void predict_word(src_word_t w);
    int first;
    first     = expected_tokens.size();
    run_count = 0;
    if (scan_state == SC_DONE) begin
      push_token(TK_EOF, ERR_NONE, cur_pos, cur_pos);
    end else if (w.eot || w.ch == CH_NUL) begin
      flush_text(cur_pos);
    end else begin
      scan_char(w.ch, cur_pos);
      if (cur_pos < 64'hFFFFFF) cur_pos++;
    end
    if (expected_tokens.size() > first)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  initial begin
    scan_state = SC_IDLE;
    cur_pos    = 0;
    tok_begin  = 0;
    cur_line   = 1;
    name_bytes = '0;
  end

  // --------------------------------------------------------------------------
  // Stimulus text
  // --------------------------------------------------------------------------
  src_word_t pending_words[$];
  int        fail_count = 0;
  int        words_taken = 0;

  function automatic void add_text(string s);
    src_word_t w;
    for (int i = 0; i < s.len(); i++) begin
      w.ch  = s[i];
      w.eot = 1'b0;
      pending_words.push_back(w);
    end
  endfunction

  function automatic void add_word(logic [7:0] c, logic e);
    src_word_t w;
    w.ch  = c;
    w.eot = e;
    pending_words.push_back(w);
  endfunction

  function automatic string rand_name(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: s = {s, string'(8'($urandom_range("a", "z")))};
        1: s = {s, string'(8'($urandom_range("A", "Z")))};
        2: s = {s, (i == 0) ? "_" : string'(8'($urandom_range("0", "9")))};
        default: s = {s, "a"};
      endcase
    end
    return s;
  endfunction

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("0", "9")))};
    return s;
  endfunction

  // Mostly well-formed lexemes with random content, some raw noise bytes.
  function automatic void add_fragment();
    string ops[] = '{"(", ")", "{", "}", ",", ".", "-", "+", ";", "/", "*", "!",
                     "!=", "<-", "==", ">", ">=", "<", "<=", "->", "="};
    case ($urandom_range(0, 11))
      0, 1: add_text(kw_text[$urandom_range(0, 15)]);
      2:    add_text(rand_name($urandom_range(1, 10)));
      3:    add_text(rand_digits($urandom_range(1, 4)));
      4:    add_text({rand_digits($urandom_range(1, 3)), ".",
                      rand_digits($urandom_range(0, 2))});
      5:    add_text({"\"", rand_name($urandom_range(0, 4)),
                      ($urandom_range(0, 1) ? "\n" : " "), "\""});
      6, 7: add_text(ops[$urandom_range(0, ops.size() - 1)]);
      8:    add_text({"//", rand_name($urandom_range(0, 5)), "\n"});
      9:    add_word($urandom_range(1, 255), 1'b0);
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0: add_text(" ");
      1: add_text("\n");
      2: add_text("\t");
      3: add_text("\r");
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one word per handshake, random idle bursts until the calm tail.
  // --------------------------------------------------------------------------
  int src_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid       <= 1'b0;
      in_ch.char_code   <= '0;
      in_ch.end_of_text <= 1'b0;
      src_gap           <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_word('{in_ch.char_code, in_ch.end_of_text});
        words_taken <= words_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          in_ch.valid <= 1'b0;
          src_gap     <= src_gap - 1;
        end else if (pending_words.size() > 0) begin
          src_word_t w;
          w = pending_words.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.char_code   <= w.ch;
          in_ch.end_of_text <= w.eot;
          if (pending_words.size() > 60 && $urandom_range(0, 7) == 0)
            src_gap <= $urandom_range(1, 12);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off: stop draining once so the run queue fills and backs up.
  // --------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 0;

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && words_taken >= 150) begin
      hold_left <= 200;
      hold_done <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare every accepted token against the oldest prediction.
  // --------------------------------------------------------------------------
  int sink_gap = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: token %s mismatch: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    token_t t;
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_gap     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected", out_ch.token_kind, 0);
        end else begin
          t = expected_tokens.pop_front();
          if (out_ch.token_kind !== t.kind)    report_mismatch("kind", out_ch.token_kind, t.kind);
          if (out_ch.error_kind !== t.err)     report_mismatch("error", out_ch.error_kind, t.err);
          if (out_ch.start_offset !== t.start) report_mismatch("start", out_ch.start_offset, t.start);
          if (out_ch.token_length !== t.len)   report_mismatch("length", out_ch.token_length, t.len);
          if (out_ch.line_number !== t.line)   report_mismatch("line", out_ch.line_number, t.line);
          if (out_ch.last_of_run !== t.last)   report_mismatch("last", out_ch.last_of_run, t.last);
        end
      end
      // hold off during the long stall, else idle in random bursts
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        out_ch.ready <= 1'b0;
        sink_gap     <= sink_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (pending_words.size() > 60 && $urandom_range(0, 7) == 0)
          sink_gap <= $urandom_range(1, 12);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: directed text, random text, open string at the end, then words
  // after the end mark which must each yield a lone EOF.
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.char_code   = '0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready      = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    add_text("(){},.-+;*!x!=<-==>>=<<=->=a 12.( 3.5 \"s\n\" //c\n@tafaaulz");
    add_word(8'hFF, 1'b0);
    while (pending_words.size() < 440) add_fragment();
    add_text(" \"open\n");
    add_word(8'h00, 1'b1);  // end mark inside a string
    add_word(8'h41, 1'b0);
    add_word(CH_NUL, 1'b0);
    add_word(8'h7E, 1'b1);

    wait (pending_words.size() == 0 && !in_ch.valid);
    wait (expected_tokens.size() == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("tb_source_text_tokenizer passed");
    end else begin
      $display("tb_source_text_tokenizer failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_source_text_tokenizer failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/stt_pkg.sv
hw/rtl/stt_channels.sv
hw/rtl/stt_front.sv
hw/rtl/stt_queue.sv
hw/rtl/stt_back.sv
hw/rtl/source_text_tokenizer.sv
tb/tb_source_text_tokenizer.sv
